// File: sv/swpcl_pkg.sv
// ----------------------------------------------------------------------------
// swpcl_pkg
// Shared types and constants for the stopwatch press capture log.
// ----------------------------------------------------------------------------
package swpcl_pkg;

    localparam int DEFAULT_RECORD_DEPTH = 512;
    localparam int DEFAULT_BEEP_TICKS   = 25;

    // beat layout
    localparam int OP_W        = 3;
    localparam int INDEX_W     = 9;
    localparam int NUMBER_W    = 16;
    localparam int STORED_W    = 10;
    localparam int HOURS_W     = 8;
    localparam int MINUTES_W   = 6;
    localparam int SECONDS_W   = 6;
    localparam int HUNDREDTHS_W = 7;
    localparam int TIME_W      = HOURS_W + MINUTES_W + SECONDS_W + HUNDREDTHS_W;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 64;

    localparam logic [NUMBER_W-1:0]     NEW_RECORD_NUMBER = 16'd999;
    localparam logic [HUNDREDTHS_W-1:0] MAX_HUNDREDTHS    = 7'd99;
    localparam logic [SECONDS_W-1:0]    MAX_SECONDS       = 6'd59;
    localparam logic [MINUTES_W-1:0]    MAX_MINUTES       = 6'd59;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_POLL  = 3'd1,
        OP_READ  = 3'd2,
        OP_WRITE = 3'd3,
        OP_CLEAR = 3'd4,
        OP_ARM   = 3'd5
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;   // input beat taken, update state and launch memory read
        logic load;     // move finished result into output register
    } t_cmd;

    typedef struct packed {
        logic out_busy; // output register holds a result that is not taken this cycle
    } t_status;

endpackage

// File: sv/stopwatch_press_capture_log_core.sv
// Flow: an accepted beat updates the state and registers its record memory
// read; its result is then loaded into the output register once that
// register is free. A new beat is not taken until the result of the last
// one has been loaded into the output register.
// Reset: synchronous, active low; clears the clock, debouncer, beep timer and
// record count. The record memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// stopwatch_press_capture_log_core
// Stopwatch with debounced button press capture into a timestamp log.
// ----------------------------------------------------------------------------
module stopwatch_press_capture_log_core #(
    parameter int RECORD_DEPTH = swpcl_pkg::DEFAULT_RECORD_DEPTH,
    parameter int BEEP_TICKS   = swpcl_pkg::DEFAULT_BEEP_TICKS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // op
    input  logic [swpcl_pkg::OP_W-1:0]       i_s_axis_tuser,
    // pin_level, index, number, zero fill
    input  logic [swpcl_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // recorded, full_error, index_valid, stored_records, beep, rec_number,
    // out_hours, out_minutes, out_seconds, out_hundredths, zero fill
    output logic [swpcl_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);
    import swpcl_pkg::*;

    t_cmd    cmd;
    t_status status;

    swpcl_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    swpcl_dp #(
        .RECORD_DEPTH (RECORD_DEPTH),
        .BEEP_TICKS   (BEEP_TICKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// File: sv/swpcl_ctrl.sv
// ----------------------------------------------------------------------------
// swpcl_ctrl
// Controller: takes one input beat, then loads its result once the output
// register is free.
// ----------------------------------------------------------------------------
module swpcl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  swpcl_pkg::t_status i_status,
    output swpcl_pkg::t_cmd    o_cmd
);
    import swpcl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!i_status.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_LOAD))
        else $error("accepted beat did not move to load");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !i_status.out_busy)
        else $error("result loaded over an untaken result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.accept && o_cmd.load))
        else $error("accept and load in the same cycle");

endmodule

// File: sv/swpcl_dp.sv
// ----------------------------------------------------------------------------
// swpcl_dp
// Datapath: stopwatch, debouncer, beep timer, record memory and output
// register.
// ----------------------------------------------------------------------------
module swpcl_dp #(
    parameter int RECORD_DEPTH = swpcl_pkg::DEFAULT_RECORD_DEPTH,
    parameter int BEEP_TICKS   = swpcl_pkg::DEFAULT_BEEP_TICKS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swpcl_pkg::t_cmd                   i_cmd,
    output swpcl_pkg::t_status                o_status,
    input  logic [swpcl_pkg::OP_W-1:0]        i_s_axis_tuser,
    input  logic [swpcl_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [swpcl_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);
    import swpcl_pkg::*;

    localparam int AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
    localparam int CW = $clog2(RECORD_DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    // input fields
    t_op                  op;
    logic                 pin_level;
    logic [INDEX_W-1:0]   idx;
    logic [NUMBER_W-1:0]  num;

    assign op        = t_op'(i_s_axis_tuser);
    assign pin_level = i_s_axis_tdata[0];
    assign idx       = i_s_axis_tdata[INDEX_W:1];
    assign num       = i_s_axis_tdata[INDEX_W+NUMBER_W:INDEX_W+1];

    // state
    logic [HUNDREDTHS_W-1:0] r_hs, n_hs;
    logic [SECONDS_W-1:0]    r_sec, n_sec;
    logic [MINUTES_W-1:0]    r_min, n_min;
    logic [HOURS_W-1:0]      r_hr, n_hr;
    logic                    r_running, n_running;
    logic                    r_waiting, n_waiting;
    logic                    r_deb, n_deb;
    logic                    r_vote_lo, n_vote_lo;
    logic                    r_vote_hi, n_vote_hi;
    logic                    r_prev, n_prev;
    logic [4:0]              r_beep_cnt, n_beep_cnt;
    logic                    r_beep_hold, n_beep_hold;
    logic [CW-1:0]           r_count, n_count;

    // per-item results waiting for the load
    logic                    r_p_recorded, n_p_recorded;
    logic                    r_p_full, n_p_full;
    logic                    r_p_valid, n_p_valid;
    logic                    r_p_write;
    logic [NUMBER_W-1:0]     r_p_num;

    // record memory, number and time kept apart so a number write is one access
    logic [NUMBER_W-1:0]     mem_num  [RECORD_DEPTH];
    logic [TIME_W-1:0]       mem_time [RECORD_DEPTH];
    logic [NUMBER_W-1:0]     r_num_rd;
    logic [TIME_W-1:0]       r_time_rd;

    logic                    append;
    logic                    num_we;
    logic [AW-1:0]           num_waddr;
    logic [NUMBER_W-1:0]     num_wdata;
    logic [AW-1:0]           rd_addr;

    // tick increments
    logic [HUNDREDTHS_W-1:0] t_hs;
    logic [SECONDS_W-1:0]    t_sec;
    logic [MINUTES_W-1:0]    t_min;
    logic [HOURS_W-1:0]      t_hr;

    logic                    delta, flip, press;

    always_comb begin
        t_hs  = r_hs + 1'b1;
        t_sec = r_sec;
        t_min = r_min;
        t_hr  = r_hr;
        if (t_hs > MAX_HUNDREDTHS) begin
            t_hs  = '0;
            t_sec = r_sec + 1'b1;
        end
        if (t_sec > MAX_SECONDS) begin
            t_sec = '0;
            t_min = r_min + 1'b1;
        end
        if (t_min > MAX_MINUTES) begin
            t_min = '0;
            t_hr  = r_hr + 1'b1;
        end
    end

    // vertical counter: level flips after three differing samples in a row
    assign delta     = pin_level ^ r_deb;
    assign n_vote_hi = (r_vote_hi ^ r_vote_lo) & delta;
    assign n_vote_lo = ~r_vote_lo & delta;
    assign flip      = n_vote_lo & n_vote_hi;
    assign n_deb     = r_deb ^ flip;
    assign press     = (r_prev != n_deb) && !n_deb;

    always_comb begin
        n_hs         = r_hs;
        n_sec        = r_sec;
        n_min        = r_min;
        n_hr         = r_hr;
        n_running    = r_running;
        n_waiting    = r_waiting;
        n_prev       = r_prev;
        n_beep_cnt   = r_beep_cnt;
        n_beep_hold  = r_beep_hold;
        n_count      = r_count;
        n_p_recorded = 1'b0;
        n_p_full     = 1'b0;
        n_p_valid    = 1'b0;
        append       = 1'b0;
        num_we       = 1'b0;
        num_waddr    = AW'(r_count);
        num_wdata    = NEW_RECORD_NUMBER;
        rd_addr      = AW'(idx);
        unique case (op)
            OP_TICK: begin
                if (r_running) begin
                    n_hs  = t_hs;
                    n_sec = t_sec;
                    n_min = t_min;
                    n_hr  = t_hr;
                end
                if (r_beep_cnt != '0) begin
                    n_beep_cnt = r_beep_cnt - 1'b1;
                end
            end
            OP_POLL: begin
                n_prev = n_deb;
                if (press) begin
                    if (r_waiting) begin
                        n_waiting   = 1'b0;
                        n_beep_hold = 1'b0;
                        n_beep_cnt  = '0;
                        n_running   = 1'b1;
                    end else begin
                        if (r_beep_cnt == '0) begin
                            n_beep_cnt = 5'(BEEP_TICKS);
                        end
                        if (r_count < CW'(RECORD_DEPTH)) begin
                            append       = 1'b1;
                            num_we       = 1'b1;
                            n_count      = r_count + 1'b1;
                            n_p_recorded = 1'b1;
                        end else begin
                            n_p_full = 1'b1;
                        end
                    end
                end
            end
            OP_READ, OP_WRITE: begin
                // count never exceeds the depth, so this also bounds the address
                if (XW'(idx) < XW'(r_count)) begin
                    n_p_valid = 1'b1;
                    if (op == OP_WRITE) begin
                        num_we    = 1'b1;
                        num_waddr = AW'(idx);
                        num_wdata = num;
                    end
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_ARM: begin
                n_running   = 1'b0;
                n_hs        = '0;
                n_sec       = '0;
                n_min       = '0;
                n_hr        = '0;
                n_waiting   = 1'b1;
                n_beep_hold = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs        <= '0;
            r_sec       <= '0;
            r_min       <= '0;
            r_hr        <= '0;
            r_running   <= 1'b1;
            r_waiting   <= 1'b0;
            r_deb       <= 1'b1;
            r_vote_lo   <= 1'b0;
            r_vote_hi   <= 1'b0;
            r_prev      <= 1'b1;
            r_beep_cnt  <= '0;
            r_beep_hold <= 1'b0;
            r_count     <= '0;
        end else if (i_cmd.accept) begin
            r_hs        <= n_hs;
            r_sec       <= n_sec;
            r_min       <= n_min;
            r_hr        <= n_hr;
            r_running   <= n_running;
            r_waiting   <= n_waiting;
            r_beep_cnt  <= n_beep_cnt;
            r_beep_hold <= n_beep_hold;
            r_count     <= n_count;
            if (op == OP_POLL) begin
                r_deb     <= n_deb;
                r_vote_lo <= n_vote_lo;
                r_vote_hi <= n_vote_hi;
                r_prev    <= n_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_recorded <= n_p_recorded;
            r_p_full     <= n_p_full;
            r_p_valid    <= n_p_valid;
            r_p_write    <= (op == OP_WRITE);
            r_p_num      <= num;
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && num_we) begin
            mem_num[num_waddr] <= num_wdata;
        end
        if (i_cmd.accept && append) begin
            mem_time[AW'(r_count)] <= {r_hr, r_min, r_sec, r_hs};
        end
        if (i_cmd.accept) begin
            r_num_rd  <= mem_num[rd_addr];
            r_time_rd <= mem_time[rd_addr];
        end
    end

    // output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [NUMBER_W-1:0]  res_number;
    logic [TIME_W-1:0]    res_time;
    logic                 res_beep;

    assign res_number = !r_p_valid ? '0 : (r_p_write ? r_p_num : r_num_rd);
    assign res_time   = r_p_valid ? r_time_rd : {r_hr, r_min, r_sec, r_hs};
    assign res_beep   = r_beep_hold || (r_beep_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= {7'd0, res_time[HUNDREDTHS_W-1:0],
                           res_time[HUNDREDTHS_W+SECONDS_W-1:HUNDREDTHS_W],
                           res_time[HUNDREDTHS_W+SECONDS_W+MINUTES_W-1:
                                    HUNDREDTHS_W+SECONDS_W],
                           res_time[TIME_W-1:TIME_W-HOURS_W],
                           res_number, res_beep, STORED_W'(r_count),
                           r_p_valid, r_p_full, r_p_recorded};
        end
    end

    assign o_status.out_busy = r_out_valid && !i_m_axis_tready;
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RECORD_DEPTH))
        else $error("record count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && append) |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not advance the record count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]))
        else $error("recorded and full flagged together");

endmodule
